// ===== hdl/scan_time_to_collision_brake_unit_defines.svh =====
// ----------------------------------------------------------------------------
// scan ttc brake assertion macros
// shared concurrent assertion forms for the brake unit checker
// ----------------------------------------------------------------------------
`ifndef SCAN_TIME_TO_COLLISION_BRAKE_UNIT_DEFINES_SVH
`define SCAN_TIME_TO_COLLISION_BRAKE_UNIT_DEFINES_SVH

// same-cycle implication, muted while reset is applied
`define STTCB_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sttcb assertion failed");

// next-cycle implication, muted while reset is applied
`define STTCB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("sttcb assertion failed");

`endif

// ===== hdl/sttcb_pkg.sv =====
// ----------------------------------------------------------------------------
// sttcb package
// types, register codes and cosine table helper for the ttc brake unit
// ----------------------------------------------------------------------------
package sttcb_pkg;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int NUM_W   = 16;
  localparam int DEN_W   = 31;
  localparam int COS_W   = 16;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_EGO_SPEED   = 3'd0;
  localparam logic [2:0] REG_ANGLE_START = 3'd1;
  localparam logic [2:0] REG_ANGLE_STEP  = 3'd2;
  localparam logic [2:0] REG_RANGE_LIMIT = 3'd3;
  localparam logic [2:0] REG_BRAKE_TTC   = 3'd4;
  localparam logic [2:0] REG_REAR_OFFSET = 3'd5;

  localparam logic [15:0] RANGE_LIMIT_RST = 16'hFFFF;
  localparam logic [15:0] BRAKE_TTC_RST   = 16'd205;
  localparam logic [15:0] REAR_OFFSET_RST = 16'd51;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  typedef struct packed {
    logic signed [15:0] ego_speed;
    logic [15:0]        angle_start;
    logic [15:0]        angle_step;
    logic [15:0]        range_limit;
    logic [15:0]        brake_ttc;
    logic [15:0]        rear_offset;
  } cfg_t;

  // one classified beam handed from front to back
  typedef struct packed {
    logic             have;
    logic             last;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } desc_t;

  // cosine of a Q30 angle by taylor series, rounded to frac bits
  function automatic logic [COS_W-1:0] cos_entry(input logic [63:0] x, input int frac);
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        r;
    term = ONE_Q30;
    sum  = $signed(ONE_Q30);
    for (int k = 1; k <= 14; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > $signed(ONE_Q30)) begin
      sum = $signed(ONE_Q30);
    end
    r = ($unsigned(sum) + (64'd1 << (29 - frac))) >> (30 - frac);
    return (r > 64'd65535) ? 16'hFFFF : r[COS_W-1:0];
  endfunction

endpackage

// ===== hdl/sttcb_if.sv =====
// ----------------------------------------------------------------------------
// sttcb stream interfaces
// valid/ready channels for beam samples and scan results
// ----------------------------------------------------------------------------
interface sttcb_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] range_sample;
  logic        scan_last;

  modport source (output valid, range_sample, scan_last, input ready);
  modport sink (input valid, range_sample, scan_last, output ready);
endinterface

interface sttcb_out_if;
  logic        valid;
  logic        ready;
  logic        brake;
  logic [15:0] min_ttc;
  logic        ttc_found;

  modport source (output valid, brake, min_ttc, ttc_found, input ready);
  modport sink (input valid, brake, min_ttc, ttc_found, output ready);
endinterface

// ===== hdl/scan_time_to_collision_brake_unit.sv =====
// flow: the front end accepts a beam, multiplies and classifies it, and runs
//   ahead of the back end through a two-entry queue; it takes the next beam
//   once the last one is pushed. the bit-serial back end pops a beam, runs 16
//   restoring steps (skipped when the beam has no ttc or would overflow) and
//   updates the minimum; the result is registered on the last beam's update
// reset: asynchronous, clears control state and loads register reset values;
//   the cosine table is constant, so there is no clearing pass
// ----------------------------------------------------------------------------
// scan time-to-collision brake unit
// per-beam lidar time to collision with end-of-scan minimum and brake flag
// ----------------------------------------------------------------------------
module scan_time_to_collision_brake_unit #(
  parameter int COS_TABLE_DEPTH = 256,
  parameter int COS_FRAC_BITS   = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  sttcb_in_if.sink                      in_ch_i,
  sttcb_out_if.source                   out_ch_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sttcb_pkg::PADDR_W-1:0] paddr,
  input  logic [sttcb_pkg::PDATA_W-1:0] pwdata,
  output logic [sttcb_pkg::PDATA_W-1:0] prdata,
  output logic                          pready
);

  // configuration registers
  sttcb_pkg::cfg_t  cfg_q;
  logic             cfg_wr;
  logic [2:0]       cfg_idx;
  logic [15:0]      rd_val;

  // front to queue to back
  logic             push;
  sttcb_pkg::desc_t push_data;
  logic             full;
  logic             pop;
  sttcb_pkg::desc_t pop_data;
  logic             empty;

  // apb: zero wait states, write lands on the access phase
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ego_speed   <= 16'sd0;
      cfg_q.angle_start <= 16'd0;
      cfg_q.angle_step  <= 16'd0;
      cfg_q.range_limit <= sttcb_pkg::RANGE_LIMIT_RST;
      cfg_q.brake_ttc   <= sttcb_pkg::BRAKE_TTC_RST;
      cfg_q.rear_offset <= sttcb_pkg::REAR_OFFSET_RST;
    end else if (cfg_wr) begin
      // indexes past the register list are dropped
      unique case (cfg_idx)
        sttcb_pkg::REG_EGO_SPEED:   cfg_q.ego_speed   <= $signed(pwdata[15:0]);
        sttcb_pkg::REG_ANGLE_START: cfg_q.angle_start <= pwdata[15:0];
        sttcb_pkg::REG_ANGLE_STEP:  cfg_q.angle_step  <= pwdata[15:0];
        sttcb_pkg::REG_RANGE_LIMIT: cfg_q.range_limit <= pwdata[15:0];
        sttcb_pkg::REG_BRAKE_TTC:   cfg_q.brake_ttc   <= pwdata[15:0];
        sttcb_pkg::REG_REAR_OFFSET: cfg_q.rear_offset <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // readback, zero-extended to the bus width
  always_comb begin
    unique case (cfg_idx)
      sttcb_pkg::REG_EGO_SPEED:   rd_val = cfg_q.ego_speed;
      sttcb_pkg::REG_ANGLE_START: rd_val = cfg_q.angle_start;
      sttcb_pkg::REG_ANGLE_STEP:  rd_val = cfg_q.angle_step;
      sttcb_pkg::REG_RANGE_LIMIT: rd_val = cfg_q.range_limit;
      sttcb_pkg::REG_BRAKE_TTC:   rd_val = cfg_q.brake_ttc;
      sttcb_pkg::REG_REAR_OFFSET: rd_val = cfg_q.rear_offset;
      default:                    rd_val = 16'd0;
    endcase
  end
  assign prdata = {16'd0, rd_val};

  // front: beam angle, cosine lookup, projected speed, sign checks;
  // each item leaves as a descriptor with numerator, divisor and flags
  sttcb_front #(
    .COS_TABLE_DEPTH (COS_TABLE_DEPTH),
    .COS_FRAC_BITS   (COS_FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_ch_i     (in_ch_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  // short queue so the front keeps taking beams while the divider works
  sttcb_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  // back: saturating divide, running minimum, result register on last beam
  sttcb_back #(
    .COS_FRAC_BITS (COS_FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .empty_i    (empty),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .out_ch_o   (out_ch_o)
  );

endmodule

// ===== hdl/sttcb_front.sv =====
// ----------------------------------------------------------------------------
// sttcb front end
// tracks beam angle, looks up cosine, projects speed and classifies beams
// ----------------------------------------------------------------------------
module sttcb_front #(
  parameter int COS_TABLE_DEPTH = 256,
  parameter int COS_FRAC_BITS   = 14
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sttcb_pkg::cfg_t   cfg_i,
  sttcb_in_if.sink          in_ch_i,
  output logic              push_o,
  output sttcb_pkg::desc_t  push_data_o,
  input  logic              full_i
);

  localparam int AW   = $clog2(COS_TABLE_DEPTH + 1);
  localparam int PW   = 14 + AW;
  localparam int VP_W = 33;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_CLS  = 2'd2;

  logic [sttcb_pkg::COS_W-1:0] cos_rom [COS_TABLE_DEPTH+1];

  for (genvar gi = 0; gi <= COS_TABLE_DEPTH; gi++) begin : g_rom
    localparam logic [63:0] XQ = (64'(gi) * sttcb_pkg::PI_Q30) / (2 * COS_TABLE_DEPTH);
    assign cos_rom[gi] = sttcb_pkg::cos_entry(XQ, COS_FRAC_BITS);
  end

  logic [1:0]                  state_q, state_d;
  logic [15:0]                 angle_q;
  logic [15:0]                 range_q;
  logic                        last_q;
  logic                        cnt_q;
  logic                        neg_q;
  logic [sttcb_pkg::COS_W-1:0] cos_q;
  logic signed [VP_W-1:0]      vp_q;

  logic                        accept;
  logic [PW-1:0]               idx_prod;
  logic [AW-1:0]               idx;
  logic [AW-1:0]               rom_addr;
  logic signed [16:0]          cos_s;
  logic signed [VP_W-1:0]      vp_mul;
  logic                        fwd;
  logic                        vp_neg;
  logic                        vp_nz;
  logic [VP_W-1:0]             vp_abs;
  logic signed [16:0]          num_s;
  logic [16:0]                 num_abs;

  assign in_ch_i.ready = (state_q == F_IDLE);
  assign accept        = in_ch_i.valid && in_ch_i.ready;

  // quarter-wave lookup, quadrants one and three read the mirrored entry
  assign idx_prod = PW'(angle_q[13:0]) * PW'(COS_TABLE_DEPTH);
  assign idx      = idx_prod[14 +: AW];
  assign rom_addr = angle_q[14] ? (AW'(COS_TABLE_DEPTH) - idx) : idx;

  assign cos_s  = neg_q ? -$signed({1'b0, cos_q}) : $signed({1'b0, cos_q});
  assign vp_mul = VP_W'(cfg_i.ego_speed) * VP_W'(cos_s);

  assign fwd     = !cfg_i.ego_speed[15] && (cfg_i.ego_speed != 16'sd0);
  assign vp_neg  = vp_q[VP_W-1];
  assign vp_nz   = (vp_q != '0);
  assign vp_abs  = vp_neg ? VP_W'(-vp_q) : VP_W'(vp_q);
  assign num_s   = $signed({1'b0, range_q}) - $signed({1'b0, cfg_i.rear_offset});
  assign num_abs = num_s[16] ? 17'(-num_s) : 17'(num_s);

  always_comb begin
    push_data_o.last = last_q;
    push_data_o.den  = vp_abs[sttcb_pkg::DEN_W-1:0];
    if (fwd) begin
      push_data_o.have = cnt_q && vp_nz && !vp_neg;
      push_data_o.num  = range_q;
    end else begin
      push_data_o.have = cnt_q && vp_nz && (num_s != 17'sd0) && (num_s[16] == vp_neg);
      push_data_o.num  = num_abs[sttcb_pkg::NUM_W-1:0];
    end
  end

  assign push_o = (state_q == F_CLS) && !full_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: begin
        if (accept) state_d = F_MUL;
      end
      F_MUL: state_d = F_CLS;
      F_CLS: begin
        if (!full_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      angle_q <= 16'd0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        angle_q <= in_ch_i.scan_last ? cfg_i.angle_start : angle_q + cfg_i.angle_step;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      range_q <= in_ch_i.range_sample;
      last_q  <= in_ch_i.scan_last;
      cnt_q   <= (in_ch_i.range_sample != 16'd0) &&
                 (in_ch_i.range_sample < cfg_i.range_limit);
      neg_q   <= angle_q[15] ^ angle_q[14];
      cos_q   <= cos_rom[rom_addr];
    end
    if (state_q == F_MUL) begin
      vp_q <= vp_mul;
    end
  end

endmodule

// ===== hdl/sttcb_fifo.sv =====
// ----------------------------------------------------------------------------
// sttcb descriptor queue
// two-entry queue between front end and divider back end
// ----------------------------------------------------------------------------
module sttcb_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sttcb_pkg::desc_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output sttcb_pkg::desc_t pop_data_o,
  output logic             empty_o
);

  sttcb_pkg::desc_t mem_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       count_q;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// ===== hdl/sttcb_back.sv =====
// ----------------------------------------------------------------------------
// sttcb back end
// restoring divider, running minimum and scan result register
// ----------------------------------------------------------------------------
module sttcb_back #(
  parameter int COS_FRAC_BITS = 14
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sttcb_pkg::cfg_t  cfg_i,
  input  logic             empty_i,
  input  sttcb_pkg::desc_t pop_data_i,
  output logic             pop_o,
  sttcb_out_if.source      out_ch_o
);

  localparam int SHIFT = COS_FRAC_BITS - 8;
  localparam int RW    = sttcb_pkg::DEN_W + 1;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_DIV  = 2'd1;
  localparam logic [1:0] B_UPD  = 2'd2;

  logic [1:0]                   state_q;
  logic                         have_q;
  logic                         last_q;
  logic [sttcb_pkg::DEN_W-1:0]  den_q;
  logic [RW-1:0]                rem_q;
  logic [15:0]                  quo_q;
  logic [3:0]                   step_q;
  logic [15:0]                  min_q;
  logic                         min_valid_q;
  logic                         out_valid_q;
  logic                         out_brake_q;
  logic [15:0]                  out_min_q;
  logic                         out_found_q;

  logic [RW-1:0] rem0;
  logic          ovf;
  logic [RW-1:0] rem2;
  logic          ge;
  logic [15:0]   ttc;
  logic          take;
  logic [15:0]   nmin;
  logic          nvalid;
  logic          out_free;
  logic          emit;
  logic          upd_done;

  assign pop_o = (state_q == B_IDLE) && !empty_i;

  // quotient below 2^16 exactly when scaled numerator is below divisor
  assign rem0 = RW'(pop_data_i.num) << SHIFT;
  assign ovf  = rem0 >= {1'b0, pop_data_i.den};
  assign rem2 = {rem_q[RW-2:0], 1'b0};
  assign ge   = rem2 >= {1'b0, den_q};

  assign ttc    = (quo_q == 16'd0) ? 16'd1 : quo_q;
  assign take   = have_q && (!min_valid_q || ttc < min_q);
  assign nmin   = take ? ttc : min_q;
  assign nvalid = min_valid_q || take;

  assign out_free = !out_valid_q || out_ch_o.ready;
  assign upd_done = (state_q == B_UPD) && (!last_q || out_free);
  assign emit     = (state_q == B_UPD) && last_q && out_free;

  assign out_ch_o.valid     = out_valid_q;
  assign out_ch_o.brake     = out_brake_q;
  assign out_ch_o.min_ttc   = out_min_q;
  assign out_ch_o.ttc_found = out_found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      min_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      step_q      <= 4'd0;
    end else begin
      unique case (state_q)
        B_IDLE: begin
          if (pop_o) begin
            if (pop_data_i.have && !ovf) begin
              state_q <= B_DIV;
              step_q  <= 4'd15;
            end else begin
              state_q <= B_UPD;
            end
          end
        end
        B_DIV: begin
          step_q <= step_q - 4'd1;
          if (step_q == 4'd0) state_q <= B_UPD;
        end
        B_UPD: begin
          if (upd_done) begin
            state_q     <= B_IDLE;
            min_valid_q <= last_q ? 1'b0 : nvalid;
          end
        end
        default: state_q <= B_IDLE;
      endcase
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ch_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      have_q <= pop_data_i.have;
      last_q <= pop_data_i.last;
      den_q  <= pop_data_i.den;
      rem_q  <= rem0;
      quo_q  <= (pop_data_i.have && !ovf) ? 16'd0 : 16'hFFFF;
    end
    if (state_q == B_DIV) begin
      rem_q <= ge ? rem2 - {1'b0, den_q} : rem2;
      quo_q <= {quo_q[14:0], ge};
    end
    if (upd_done) begin
      min_q <= last_q ? 16'd0 : nmin;
    end
    if (emit) begin
      out_brake_q <= nvalid && (nmin < cfg_i.brake_ttc);
      out_min_q   <= nvalid ? nmin : 16'd0;
      out_found_q <= nvalid;
    end
  end

endmodule

// ===== hdl/sttcb_checker.sv =====
// ----------------------------------------------------------------------------
// sttcb port checker
// result channel checks on the brake unit ports, bound to the top level
// ----------------------------------------------------------------------------
`include "scan_time_to_collision_brake_unit_defines.svh"

module sttcb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        brake_i,
  input logic [15:0] min_ttc_i,
  input logic        ttc_found_i
);

  logic [17:0] res_w;

  assign res_w = {brake_i, min_ttc_i, ttc_found_i};

  // stalled result holds
  `STTCB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(res_w))

  // brake only with a found minimum
  `STTCB_ASSERT_IMPLY(a_brake_found, clk_i, rst_ni, out_valid_i && brake_i, ttc_found_i)

  // no minimum reads as zero
  `STTCB_ASSERT_IMPLY(a_none_zero, clk_i, rst_ni, out_valid_i && !ttc_found_i, min_ttc_i == 16'd0)

  // a found minimum is never zero
  `STTCB_ASSERT_IMPLY(a_found_nz, clk_i, rst_ni, out_valid_i && ttc_found_i, min_ttc_i != 16'd0)

endmodule

bind scan_time_to_collision_brake_unit sttcb_checker u_sttcb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_ch_o.valid),
  .out_ready_i (out_ch_o.ready),
  .brake_i     (out_ch_o.brake),
  .min_ttc_i   (out_ch_o.min_ttc),
  .ttc_found_i (out_ch_o.ttc_found)
);
